### rtl/core/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/core/trap_pkg.sv
// ----------------------------------------------------------------------------
// trap_pkg
// types, codes and constants of the turn response attribute parser
// ----------------------------------------------------------------------------
package trap_pkg;

    localparam int MAX_TEXT_DEFAULT = 128;

    localparam logic [15:0] T_ERROR    = 16'h0009;
    localparam logic [15:0] T_LIFETIME = 16'h000D;
    localparam logic [15:0] T_REALM    = 16'h0014;
    localparam logic [15:0] T_NONCE    = 16'h0015;
    localparam logic [15:0] T_XRELAY   = 16'h0016;

    localparam logic [1:0] KIND_REALM   = 2'd0;
    localparam logic [1:0] KIND_NONCE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_OVERRUN  = 2'd3;

    localparam logic [1:0] REG_REALM_KNOWN = 2'd0;
    localparam logic [1:0] REG_NONCE_KNOWN = 2'd1;
    localparam logic [1:0] REG_XOR_KEY     = 2'd2;

    localparam logic [31:0] XOR_KEY_RESET = 32'd554869826;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value_byte;
        logic [1:0]  status;
        logic [14:0] error_code;
        logic [15:0] relayed_port;
        logic [31:0] relayed_address;
        logic [31:0] lifetime;
        logic [7:0]  realm_length;
        logic [7:0]  nonce_length;
        logic        run_last;
    } out_word_t;

    // what the front hands to the back for one byte
    typedef struct packed {
        logic       text_valid;
        logic [1:0] text_kind;
        logic [7:0] text_byte;
        logic       sum_valid;
        out_word_t  summary;
    } job_t;

endpackage

### rtl/core/turn_response_attribute_parser.sv
// turn response attribute parser
// a byte's job is registered into the result queue when the byte is accepted
// throughput: one byte per cycle while the queue is not full; a byte with text and summary needs two pops
// the front parser handles each byte as it is accepted, the result queue holds four jobs
// reset: rst_n asynchronous active low resets parse state, queue and registers
// ----------------------------------------------------------------------------
// turn_response_attribute_parser
// stun/turn response parser with configuration port
// ----------------------------------------------------------------------------
module turn_response_attribute_parser #(
    parameter int MAX_TEXT = trap_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  trap_pkg::in_word_t  item_word,
    output logic                empty,
    input  logic                pop,
    output trap_pkg::out_word_t result_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic        realm_known_reg, nonce_known_reg;
    logic [31:0] xor_key_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;
    trap_pkg::job_t job;
    logic        accept;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign accept = push && !full;

    always_comb
    begin
        case (reg_idx)
            trap_pkg::REG_REALM_KNOWN: prdata = {31'd0, realm_known_reg};
            trap_pkg::REG_NONCE_KNOWN: prdata = {31'd0, nonce_known_reg};
            trap_pkg::REG_XOR_KEY:     prdata = xor_key_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            realm_known_reg <= 1'b0;
            nonce_known_reg <= 1'b0;
            xor_key_reg <= trap_pkg::XOR_KEY_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                trap_pkg::REG_REALM_KNOWN: realm_known_reg <= pwdata[0];
                trap_pkg::REG_NONCE_KNOWN: nonce_known_reg <= pwdata[0];
                trap_pkg::REG_XOR_KEY:     xor_key_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    trap_front #(.MAX_TEXT(MAX_TEXT)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(accept),
        .byte_word(item_word),
        .realm_known(realm_known_reg),
        .nonce_known(nonce_known_reg),
        .xor_key(xor_key_reg),
        .job(job)
    );

    trap_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .job_push(accept),
        .job_data(job),
        .job_full(full),
        .res_empty(empty),
        .res_pop(pop),
        .res_word(result_word)
    );

endmodule

### rtl/core/trap_front.sv
// ----------------------------------------------------------------------------
// trap_front
// byte parser: header, attribute walk, capture and summary build
// ----------------------------------------------------------------------------
module trap_front #(
    parameter int MAX_TEXT = trap_pkg::MAX_TEXT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  trap_pkg::in_word_t byte_word,
    input  logic              realm_known,
    input  logic              nonce_known,
    input  logic [31:0]       xor_key,
    output trap_pkg::job_t    job
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_ATTR_HDR = 3'd1;
    localparam logic [2:0] PH_VALUE   = 3'd2;
    localparam logic [2:0] PH_PAD     = 3'd3;
    localparam logic [2:0] PH_DRAIN   = 3'd4;
    localparam logic [2:0] PH_OVERRUN = 3'd5;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] MAX_TEXT_W = 16'(MAX_TEXT);

    logic [16:0] byte_count_reg, byte_count_next;
    logic [15:0] msg_len_reg, msg_len_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] attr_type_reg, attr_type_next;
    logic [15:0] attr_rem_reg, attr_rem_next;
    logic [15:0] attr_off_reg, attr_off_next;
    logic [1:0]  pad_rem_reg, pad_rem_next;
    logic [63:0] win_reg, win_next;
    logic [14:0] err_reg, err_next;
    logic [15:0] port_reg, port_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] life_reg, life_next;
    logic [7:0]  rlen_reg, rlen_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic        realm_taken_reg, realm_taken_next;

    logic [7:0]  b;
    logic [16:0] pos, end_pos;
    logic [15:0] hlen;
    logic [63:0] fwin;
    logic [7:0]  fin_len_sat;
    logic [1:0]  fin_pad;
    logic        do_finish;
    logic [15:0] fin_len;
    logic [1:0]  st;

    always_comb
    begin
        b = byte_word.data_byte;
        pos = byte_count_reg;
        end_pos = 17'd20 + {1'b0, msg_len_reg};
        byte_count_next = byte_count_reg;
        msg_len_next = msg_len_reg;
        phase_next = phase_reg;
        attr_type_next = attr_type_reg;
        attr_rem_next = attr_rem_reg;
        attr_off_next = attr_off_reg;
        pad_rem_next = pad_rem_reg;
        win_next = win_reg;
        err_next = err_reg;
        port_next = port_reg;
        addr_next = addr_reg;
        life_next = life_reg;
        rlen_next = rlen_reg;
        nlen_next = nlen_reg;
        realm_taken_next = realm_taken_reg;
        do_finish = 1'b0;
        fin_len = attr_off_reg;
        fwin = win_reg;
        hlen = 16'd0;
        job = '0;
        st = trap_pkg::ST_OK;

        if (byte_count_reg < COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 17'd1;
        end

        case (phase_reg)
            PH_HEADER:
            begin
                if (pos == 17'd2)
                begin
                    msg_len_next[15:8] = b;
                end
                else if (pos == 17'd3)
                begin
                    msg_len_next[7:0] = b;
                end
                if (pos >= 17'd19)
                begin
                    phase_next = PH_ATTR_HDR;
                    attr_off_next = 16'd0;
                    win_next = '0;
                end
            end
            PH_ATTR_HDR:
            begin
                if (attr_off_reg == 16'd0 && ({1'b0, pos} + 18'd4) > {1'b0, end_pos})
                begin
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    case (attr_off_reg[1:0])
                        2'd0: win_next[63:56] = b;
                        2'd1: win_next[55:48] = b;
                        2'd2: win_next[47:40] = b;
                        default: win_next[39:32] = b;
                    endcase
                    attr_off_next = attr_off_reg + 16'd1;
                    if (attr_off_reg >= 16'd3)
                    begin
                        hlen = win_next[47:32];
                        attr_type_next = win_next[63:48];
                        attr_off_next = 16'd0;
                        win_next = '0;
                        // overrun if the value past the already bumped count runs beyond the end
                        if (({2'b0, hlen} + {1'b0, byte_count_next}) > {1'b0, end_pos}
                            || byte_count_next > end_pos)
                        begin
                            phase_next = PH_OVERRUN;
                        end
                        else if (hlen == 16'd0)
                        begin
                            do_finish = 1'b1;
                            fin_len = 16'd0;
                            fwin = '0;
                        end
                        else
                        begin
                            attr_rem_next = hlen;
                            phase_next = PH_VALUE;
                        end
                    end
                end
            end
            PH_VALUE:
            begin
                if (attr_off_reg < MAX_TEXT_W)
                begin
                    if (attr_type_reg == trap_pkg::T_REALM && !realm_known
                        && !realm_taken_reg)
                    begin
                        job.text_valid = 1'b1;
                        job.text_kind = trap_pkg::KIND_REALM;
                        job.text_byte = b;
                    end
                    else if (attr_type_reg == trap_pkg::T_NONCE && !nonce_known)
                    begin
                        job.text_valid = 1'b1;
                        job.text_kind = trap_pkg::KIND_NONCE;
                        job.text_byte = b;
                    end
                end
                if (attr_off_reg < 16'd8)
                begin
                    case (attr_off_reg[2:0])
                        3'd0: win_next[63:56] = b;
                        3'd1: win_next[55:48] = b;
                        3'd2: win_next[47:40] = b;
                        3'd3: win_next[39:32] = b;
                        3'd4: win_next[31:24] = b;
                        3'd5: win_next[23:16] = b;
                        3'd6: win_next[15:8] = b;
                        default: win_next[7:0] = b;
                    endcase
                end
                attr_off_next = attr_off_reg + 16'd1;
                attr_rem_next = attr_rem_reg - 16'd1;
                if (attr_rem_next == 16'd0)
                begin
                    do_finish = 1'b1;
                    fin_len = attr_off_next;
                    fwin = win_next;
                end
            end
            PH_PAD:
            begin
                pad_rem_next = pad_rem_reg - 2'd1;
                if (pad_rem_next == 2'd0)
                begin
                    phase_next = PH_ATTR_HDR;
                end
            end
            default:
            begin
            end
        endcase

        fin_len_sat = (fin_len > MAX_TEXT_W) ? MAX_TEXT_W[7:0] : fin_len[7:0];
        if (do_finish)
        begin
            case (attr_type_next)
                trap_pkg::T_ERROR:
                    err_next = 15'({7'd0, fwin[47:40]} * 15'd100) + {7'd0, fwin[39:32]};
                trap_pkg::T_XRELAY:
                begin
                    port_next = fwin[47:32] ^ xor_key[31:16];
                    addr_next = fwin[31:0] ^ xor_key;
                end
                trap_pkg::T_LIFETIME:
                    life_next = fwin[63:32];
                trap_pkg::T_REALM:
                begin
                    if (!realm_known && !realm_taken_reg && fin_len != 16'd0)
                    begin
                        realm_taken_next = 1'b1;
                        rlen_next = fin_len_sat;
                    end
                end
                trap_pkg::T_NONCE:
                begin
                    if (!nonce_known)
                    begin
                        nlen_next = fin_len_sat;
                    end
                end
                default:
                begin
                end
            endcase
            fin_pad = 2'd0 - fin_len[1:0];
            win_next = '0;
            attr_off_next = 16'd0;
            attr_rem_next = 16'd0;
            if (fin_pad != 2'd0)
            begin
                pad_rem_next = fin_pad;
                phase_next = PH_PAD;
            end
            else
            begin
                phase_next = PH_ATTR_HDR;
            end
        end
        else
        begin
            fin_pad = 2'd0;
        end

        if (byte_word.last_byte)
        begin
            if (byte_count_next < 17'd20)
            begin
                st = trap_pkg::ST_SHORT;
            end
            else if (byte_count_next != 17'd20 + {1'b0, msg_len_next})
            begin
                st = trap_pkg::ST_MISMATCH;
            end
            else if (phase_next == PH_OVERRUN)
            begin
                st = trap_pkg::ST_OVERRUN;
            end
            job.sum_valid = 1'b1;
            job.summary.kind = trap_pkg::KIND_SUMMARY;
            job.summary.status = st;
            job.summary.run_last = 1'b1;
            if (st == trap_pkg::ST_OK || st == trap_pkg::ST_OVERRUN)
            begin
                job.summary.error_code = err_next;
                job.summary.relayed_port = port_next;
                job.summary.relayed_address = addr_next;
                job.summary.lifetime = life_next;
                job.summary.realm_length = rlen_next;
                job.summary.nonce_length = nlen_next;
            end
        end
        if (!byte_valid)
        begin
            job = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            msg_len_reg <= '0;
            phase_reg <= PH_HEADER;
            attr_type_reg <= '0;
            attr_rem_reg <= '0;
            attr_off_reg <= '0;
            pad_rem_reg <= '0;
            win_reg <= '0;
            err_reg <= '0;
            port_reg <= '0;
            addr_reg <= '0;
            life_reg <= '0;
            rlen_reg <= '0;
            nlen_reg <= '0;
            realm_taken_reg <= 1'b0;
        end
        else if (byte_valid)
        begin
            if (byte_word.last_byte)
            begin
                byte_count_reg <= '0;
                msg_len_reg <= '0;
                phase_reg <= PH_HEADER;
                attr_type_reg <= '0;
                attr_rem_reg <= '0;
                attr_off_reg <= '0;
                pad_rem_reg <= '0;
                win_reg <= '0;
                err_reg <= '0;
                port_reg <= '0;
                addr_reg <= '0;
                life_reg <= '0;
                rlen_reg <= '0;
                nlen_reg <= '0;
                realm_taken_reg <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                msg_len_reg <= msg_len_next;
                phase_reg <= phase_next;
                attr_type_reg <= attr_type_next;
                attr_rem_reg <= attr_rem_next;
                attr_off_reg <= attr_off_next;
                pad_rem_reg <= pad_rem_next;
                win_reg <= win_next;
                err_reg <= err_next;
                port_reg <= port_next;
                addr_reg <= addr_next;
                life_reg <= life_next;
                rlen_reg <= rlen_next;
                nlen_reg <= nlen_next;
                realm_taken_reg <= realm_taken_next;
            end
        end
    end

endmodule

### rtl/core/trap_back.sv
// ----------------------------------------------------------------------------
// trap_back
// job queue and result emitter: splits a job into one or two result words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trap_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_push,
    input  trap_pkg::job_t      job_data,
    output logic                job_full,
    output logic                res_empty,
    input  logic                res_pop,
    output trap_pkg::out_word_t res_word
);

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    trap_pkg::job_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          half_reg;  // text word of the head job already sent
    trap_pkg::job_t head;
    logic          has_text, two, head_done;
    logic          push_ok, pop_ok;

    always_comb
    begin
        head = mem[rd_ptr_reg];
        has_text = head.text_valid && !half_reg;
        two = has_text && head.sum_valid;
        res_empty = (count_reg == '0);
        res_word = head.summary;
        if (has_text)
        begin
            res_word = '0;
            res_word.kind = head.text_kind;
            res_word.value_byte = head.text_byte;
            res_word.run_last = !two;
        end
        job_full = (count_reg == (AW+1)'(DEPTH));
        pop_ok = res_pop && !res_empty;
        head_done = pop_ok && !two;
        // bytes with no result are dropped at the door
        push_ok = job_push && !job_full && (job_data.text_valid || job_data.sum_valid);
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= job_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (head_done)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
                half_reg <= 1'b0;
            end
            else if (pop_ok)
            begin
                half_reg <= 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push_ok) - (AW+1)'(head_done);
        end
    end

    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg <= (AW+1)'(DEPTH))
    `ASSERT_IMPLIES(a_half_needs_job, clk, rst_n, half_reg, count_reg != '0)
    `ASSERT_NEXT(a_split_second, clk, rst_n, pop_ok && two, half_reg)

endmodule
